[rtl/wrp_pkg.sv]
// Package for the weighted random pick block: transaction structs, codes,
// controller state and the command/status bundles between controller and datapath.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wrp_pkg;

  // Field widths fixed by the interface
  localparam int ACTION_W = 2;
  localparam int SLOT_W   = 6;
  localparam int WEIGHT_W = 16;
  localparam int FRAC_W   = 16;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 22;
  localparam int CFG_W    = 7;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_WEIGHTS = 64;
  localparam int DEF_WEIGHT_BITS = 16;

  // Reset value of weights_in_use
  localparam logic [CFG_W-1:0] WIU_RESET = CFG_W'(64);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_WRITE   = 2'd1,
    ACT_REBUILD = 2'd2,
    ACT_PICK    = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE   = 2'd0,
    STAT_PICKED = 2'd1,
    STAT_NONE   = 2'd2
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   random_fraction;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  picked_slot;
    logic [TOTAL_W-1:0] total;
  } out_t;

  typedef enum logic [3:0] {
    S_RESET_CLR,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_WRITE,
    S_RB_READ,
    S_RB_ACC,
    S_SRCH_READ,
    S_SRCH_CMP,
    S_SLOT_TAKE,
    S_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic item_load;
    logic clr_start;
    logic clr_step;
    logic wr_weight;
    logic rb_start;
    logic rb_acc;
    logic rb_commit;
    logic pick_start;
    logic srch_cmp;
    logic slot_take;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_t action;
    logic    clr_last;
    logic    rb_done;
    logic    no_positive;
    logic    srch_done;
    logic    out_busy;
  } stat_t;

endpackage

`default_nettype wire

[rtl/wrp_ctrl.sv]
// Controller of the weighted random pick block: sequences clear sweeps,
// writes, rebuild walks and the binary search. Uses wrp_pkg.
`default_nettype none

module wrp_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire wrp_pkg::stat_t stat,
  output wrp_pkg::cmd_t       cmd
);
  import wrp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RESET_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RESET_CLR: if (stat.clr_last) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (stat.action)
          ACT_CLEAR:   state_next = S_CLEAR;
          ACT_WRITE:   state_next = S_WRITE;
          ACT_REBUILD: state_next = S_RB_READ;
          ACT_PICK:    state_next = stat.no_positive ? S_FINISH : S_SRCH_READ;
          default:     state_next = S_FINISH;
        endcase
      end
      S_CLEAR:     if (stat.clr_last) state_next = S_FINISH;
      S_WRITE:     state_next = S_FINISH;
      S_RB_READ:   state_next = stat.rb_done ? S_FINISH : S_RB_ACC;
      S_RB_ACC:    state_next = S_RB_READ;
      S_SRCH_READ: state_next = stat.srch_done ? S_SLOT_TAKE : S_SRCH_CMP;
      S_SRCH_CMP:  state_next = S_SRCH_READ;
      S_SLOT_TAKE: state_next = S_FINISH;
      S_FINISH:    if (!stat.out_busy) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_RESET_CLR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.item_load = in_valid;
      end
      S_DECODE: begin
        cmd.clr_start  = (stat.action == ACT_CLEAR);
        cmd.rb_start   = (stat.action == ACT_REBUILD);
        cmd.pick_start = (stat.action == ACT_PICK) && !stat.no_positive;
      end
      S_CLEAR:     cmd.clr_step  = 1'b1;
      S_WRITE:     cmd.wr_weight = 1'b1;
      S_RB_READ:   cmd.rb_commit = stat.rb_done;
      S_RB_ACC:    cmd.rb_acc    = 1'b1;
      S_SRCH_READ: ;
      S_SRCH_CMP:  cmd.srch_cmp  = 1'b1;
      S_SLOT_TAKE: cmd.slot_take = 1'b1;
      S_FINISH:    cmd.out_load  = !stat.out_busy;
      default:     ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/wrp_dp.sv]
// Datapath of the weighted random pick block: weight memory, cumulative-sum
// memories, scaling multiplier, search bounds and the result register. Uses wrp_pkg.
`default_nettype none

module wrp_dp #(
  parameter int MAX_WEIGHTS = wrp_pkg::DEF_MAX_WEIGHTS,
  parameter int WEIGHT_BITS = wrp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire wrp_pkg::in_t              in_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [wrp_pkg::CFG_W-1:0] cfg_wr_data,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output wrp_pkg::out_t                  out_data,
  input  wire wrp_pkg::cmd_t             cmd,
  output wrp_pkg::stat_t                 stat
);
  import wrp_pkg::*;

  localparam int IDX_W = (MAX_WEIGHTS > 1) ? $clog2(MAX_WEIGHTS) : 1;
  localparam int CNT_W = $clog2(MAX_WEIGHTS + 1);
  localparam int TOT_W = WEIGHT_BITS + IDX_W;
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // memories
  logic [WEIGHT_BITS-1:0] weight_mem   [MAX_WEIGHTS];
  logic [TOT_W-1:0]       cum_sum_mem  [MAX_WEIGHTS];
  logic [IDX_W-1:0]       cum_slot_mem [MAX_WEIGHTS];
  logic [WEIGHT_BITS-1:0] weight_rd;
  logic [TOT_W-1:0]       cum_sum_rd;
  logic [IDX_W-1:0]       cum_slot_rd;

  // registers
  in_t                    item;
  logic [CFG_W-1:0]       weights_in_use;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       k;
  logic [TOT_W-1:0]       run;
  logic [CNT_W-1:0]       positive_count;
  logic [TOT_W-1:0]       total_sum;
  logic [TOT_W-1:0]       scaled;
  logic [IDX_W-1:0]       lo;
  logic [IDX_W-1:0]       hi;
  logic [IDX_W-1:0]       res_slot;

  logic [CMP_W-1:0]          wiu_ext;
  logic [CNT_W-1:0]          n_use;
  logic [IDX_W:0]            mid_sum;
  logic [IDX_W-1:0]          mid;
  logic [TOT_W-1:0]          run_next;
  logic [FRAC_W+TOT_W-1:0]   product;
  logic                      slot_ok;
  status_t                   res_status;

  assign wiu_ext  = CMP_W'(weights_in_use);
  assign n_use    = (wiu_ext > CMP_W'(MAX_WEIGHTS)) ? CNT_W'(MAX_WEIGHTS) : CNT_W'(wiu_ext);
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[IDX_W:1];
  assign run_next = run + TOT_W'(weight_rd);
  assign product  = (FRAC_W+TOT_W)'(item.random_fraction) * (FRAC_W+TOT_W)'(total_sum);
  assign slot_ok  = (32'(item.slot) < 32'(MAX_WEIGHTS));

  // weight memory: one write port shared by the clear sweep and writes
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      weight_mem[idx[IDX_W-1:0]] <= '0;
    end else if (cmd.wr_weight && slot_ok) begin
      weight_mem[IDX_W'(item.slot)] <= WEIGHT_BITS'(item.weight);
    end
    weight_rd <= weight_mem[idx[IDX_W-1:0]];
  end

  // cumulative list, written by the rebuild walk, read at the search midpoint
  always_ff @(posedge clk) begin
    if (cmd.rb_acc && (weight_rd != '0)) begin
      cum_sum_mem[k[IDX_W-1:0]]  <= run_next;
      cum_slot_mem[k[IDX_W-1:0]] <= idx[IDX_W-1:0];
    end
    cum_sum_rd  <= cum_sum_mem[mid];
    cum_slot_rd <= cum_slot_mem[mid];
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      weights_in_use <= WIU_RESET;
      idx            <= '0;
      positive_count <= '0;
      total_sum      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) weights_in_use <= cfg_wr_data;

      if (cmd.clr_start || cmd.rb_start) begin
        idx <= '0;
      end else if (cmd.clr_step || cmd.rb_acc) begin
        idx <= idx + CNT_W'(1);
      end

      if (cmd.clr_start) begin
        positive_count <= '0;
        total_sum      <= '0;
      end else if (cmd.rb_commit) begin
        positive_count <= k;
        total_sum      <= run;
      end

      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item     <= in_data;
      res_slot <= '0;
    end
    if (cmd.rb_start) begin
      k   <= '0;
      run <= '0;
    end else if (cmd.rb_acc && (weight_rd != '0)) begin
      k   <= k + CNT_W'(1);
      run <= run_next;
    end
    if (cmd.pick_start) begin
      scaled <= product[FRAC_W +: TOT_W];
      lo     <= '0;
      hi     <= IDX_W'(positive_count - CNT_W'(1));
    end else if (cmd.srch_cmp) begin
      if (cum_sum_rd > scaled) begin
        hi <= mid;
      end else begin
        lo <= mid + IDX_W'(1);
      end
    end
    if (cmd.slot_take) res_slot <= cum_slot_rd;
    if (cmd.out_load) begin
      out_data.status      <= res_status;
      out_data.picked_slot <= SLOT_W'(res_slot);
      out_data.total       <= TOTAL_W'(total_sum);
    end
  end

  always_comb begin
    priority if (item.action != ACT_PICK) begin
      res_status = STAT_DONE;
    end else if (positive_count == '0) begin
      res_status = STAT_NONE;
    end else begin
      res_status = STAT_PICKED;
    end
  end

  assign stat.action      = item.action;
  assign stat.clr_last    = (idx == CNT_W'(MAX_WEIGHTS - 1));
  assign stat.rb_done     = (idx == n_use);
  assign stat.no_positive = (positive_count == '0);
  assign stat.srch_done   = (lo == hi);
  assign stat.out_busy    = out_valid && !out_ready;

endmodule

`default_nettype wire

[rtl/weighted_random_pick.sv]
// Throughput: one transaction at a time; the next is accepted once the result is
// registered, and the result is held back while the previous one is not yet taken.
// Rate is set by the single read port of each memory (walk and search).
// Reset (synchronous, active high): a pass zeroing every entry of the weight memory
// with in_ready low; weights_in_use resets to 64, total and count to zero.
`default_nettype none

// Top level of the weighted random pick block: roulette-wheel selection over
// cumulative weights. Instantiates wrp_ctrl and wrp_dp; uses wrp_pkg.
module weighted_random_pick #(
  parameter int MAX_WEIGHTS = wrp_pkg::DEF_MAX_WEIGHTS,
  parameter int WEIGHT_BITS = wrp_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire wrp_pkg::in_t              in_data,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output wrp_pkg::out_t                  out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [wrp_pkg::CFG_W-1:0] cfg_wr_data
);
  import wrp_pkg::*;

  // Controller and datapath talk only through these two bundles.
  cmd_t  cmd;
  stat_t stat;

  // The controller owns the sequencing:
  //  - clear sweeps the weight memory one entry a cycle and zeroes total/count;
  //  - rebuild walks the active slots, a read and an accumulate state per slot,
  //    appending each positive weight's running sum and slot to the list;
  //  - pick scales the fraction by the total in one multiply, then bisects
  //    the list (read, compare per step) and reads the slot at the final bound.
  //    A single positive weight collapses to a zero-step search of entry 0.
  wrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the memories, the transaction register and the
  // result register, which frees the controller once the result is loaded.
  wrp_dp #(
    .MAX_WEIGHTS (MAX_WEIGHTS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule

`default_nettype wire
